/* design/bip_pkg.sv */
// ----------------------------------------------------------------------------
// bip_pkg
// Shared types, codes and helpers of the ballistic intercept predictor.
// ----------------------------------------------------------------------------
package bip_pkg;

  localparam int FRAC_BITS_DEF  = 16;
  localparam int TIMEOUT_US_DEF = 1000000;

  localparam int POS_W  = 32;
  localparam int STAT_W = 3;
  localparam int ALPHA_W = 17;
  localparam int ADDR_W = 5;

  // shared divide / square-root unit
  localparam int DSU_NUM_W = 64;
  localparam int DSU_DEN_W = 32;

  typedef logic signed [POS_W-1:0] pos_t;
  typedef logic [STAT_W-1:0]       status_t;

  localparam status_t ST_DISABLED = 3'd0;
  localparam status_t ST_PASS     = 3'd1;
  localparam status_t ST_PREDICT  = 3'd2;
  localparam status_t ST_REJECT   = 3'd3;
  localparam status_t ST_RESYNC   = 3'd4;

  localparam logic [2:0] REG_TRACK   = 3'd0;
  localparam logic [2:0] REG_PREDICT = 3'd1;
  localparam logic [2:0] REG_ALPHA   = 3'd2;
  localparam logic [2:0] REG_CATCH   = 3'd3;
  localparam logic [2:0] REG_START_X = 3'd4;
  localparam logic [2:0] REG_START_Y = 3'd5;

  typedef enum logic {DSU_DIV, DSU_SQRT} dsu_op_t;

  typedef struct packed {
    logic    start;
    dsu_op_t op;
  } dsu_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } dsu_rsp_t;

  function automatic pos_t sat32(input logic signed [71:0] v);
    logic signed [71:0] hi;
    logic signed [71:0] lo;
    hi = 72'sd2147483647;
    lo = -72'sd2147483648;
    if (v > hi) begin
      sat32 = 32'sh7FFFFFFF;
    end else if (v < lo) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage

/* design/bip_if.sv */
// ----------------------------------------------------------------------------
// bip_in_if / bip_out_if
// Valid/ready channels for ball samples and target results.
// ----------------------------------------------------------------------------
interface bip_in_if;
  import bip_pkg::*;
  logic        valid;
  logic        ready;
  pos_t        ball_x;
  pos_t        ball_y;
  pos_t        ball_z;
  logic [31:0] sample_stamp_us;
  logic [31:0] arrival_time_us;
  modport source (output valid, ball_x, ball_y, ball_z, sample_stamp_us, arrival_time_us,
                  input ready);
  modport sink (input valid, ball_x, ball_y, ball_z, sample_stamp_us, arrival_time_us,
                output ready);
endinterface

interface bip_out_if;
  import bip_pkg::*;
  logic    valid;
  logic    ready;
  pos_t    target_x;
  pos_t    target_y;
  status_t step_status;
  modport source (output valid, target_x, target_y, step_status, input ready);
  modport sink (input valid, target_x, target_y, step_status, output ready);
endinterface

/* design/bip_dsu.sv */
// ----------------------------------------------------------------------------
// bip_dsu
// Iterative unsigned divider and integer square root, one result bit a cycle.
// ----------------------------------------------------------------------------
module bip_dsu
  import bip_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  dsu_req_t             req,
  input  logic [DSU_NUM_W-1:0] num,
  input  logic [DSU_DEN_W-1:0] den,
  output dsu_rsp_t             rsp,
  output logic [DSU_NUM_W-1:0] res
);

  localparam int REM_W = DSU_DEN_W + 4;
  localparam int CNT_W = $clog2(DSU_NUM_W + 1);

  logic [DSU_NUM_W-1:0] x_r, x_nxt;
  logic [DSU_NUM_W-1:0] res_r, res_nxt;
  logic [REM_W-1:0]     rem_r, rem_nxt;
  logic [DSU_DEN_W-1:0] den_r;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  dsu_op_t              op_r;
  logic                 busy_r, done_r;

  logic [REM_W-1:0] shl, trial, sub;

  always_comb begin
    if (op_r == DSU_DIV) begin
      shl   = {rem_r[REM_W-2:0], x_r[DSU_NUM_W-1]};
      trial = REM_W'(den_r);
      x_nxt = {x_r[DSU_NUM_W-2:0], 1'b0};
    end else begin
      shl   = {rem_r[REM_W-3:0], x_r[DSU_NUM_W-1 -: 2]};
      trial = {res_r[REM_W-3:0], 2'b01};
      x_nxt = {x_r[DSU_NUM_W-3:0], 2'b00};
    end
    sub = shl - trial;
    if (!sub[REM_W-1]) begin
      rem_nxt = sub;
      res_nxt = {res_r[DSU_NUM_W-2:0], 1'b1};
    end else begin
      rem_nxt = shl;
      res_nxt = {res_r[DSU_NUM_W-2:0], 1'b0};
    end
    cnt_nxt = cnt_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !busy_r) begin
        busy_r <= 1'b1;
        op_r   <= req.op;
        x_r    <= num;
        den_r  <= den;
        rem_r  <= '0;
        res_r  <= '0;
        cnt_r  <= (req.op == DSU_DIV) ? CNT_W'(DSU_NUM_W) : CNT_W'(DSU_NUM_W / 2);
      end else if (busy_r) begin
        x_r   <= x_nxt;
        rem_r <= rem_nxt;
        res_r <= res_nxt;
        cnt_r <= cnt_nxt;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign res      = res_r;

endmodule

/* design/ballistic_intercept_predictor.sv */
// ----------------------------------------------------------------------------
// ballistic_intercept_predictor
// Tracks ball samples and predicts where the ball crosses the catch plane.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake          | payload
//  in_ch    | in  | valid/ready        | ball_x/y/z, sample_stamp_us, arrival_time_us
//  out_ch   | out | valid/ready        | target_x, target_y, step_status
//  cfg      | in  | APB psel/penable   | six registers at 4*index
//
//  One request at a time. A full prediction runs the shared divide/sqrt unit
//  for three 64-step divides and one 32-step root; the root is skipped when
//  there is no real root. Disabled, passthrough, timeout and zero-dt requests
//  skip the unit. The multiplier is one shared registered 36x36 unit.
//  Reset is synchronous; a stalled result holds in the output register and
//  the next request is taken while it waits.
// ----------------------------------------------------------------------------
module ballistic_intercept_predictor
  import bip_pkg::*;
#(
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int TIMEOUT_US = TIMEOUT_US_DEF
)(
  input  logic              clk,
  input  logic              rst_n,
  bip_in_if.sink            in_ch,
  bip_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam longint K_FALL  = ((longint'(102) << FRAC_BITS) + 500) / 1000;
  localparam longint G2_FALL = ((longint'(1962) << FRAC_BITS) + 50) / 100;
  localparam logic signed [71:0] ONE_Q  = 72'sd1 <<< FRAC_BITS;
  localparam logic signed [71:0] X_HI   = ONE_Q * 2;
  localparam logic signed [71:0] X_LO   = -(ONE_Q * 2);
  localparam logic signed [71:0] Y_HI   = (ONE_Q * 3) / 2;
  localparam logic signed [71:0] Y_LO   = -ONE_Q;
  localparam logic [31:0] TIMEOUT_W = 32'(TIMEOUT_US);

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_VDIFF, S_VDIV, S_VDIVW, S_VMA, S_VMB, S_VMIX,
    S_DV2, S_DG, S_DSUM, S_SQW, S_KS, S_T, S_XM, S_YM, S_BOX, S_FIN
  } state_t;

  // configuration
  logic        track_r, predict_r;
  logic [ALPHA_W-1:0] alpha_r;
  pos_t        catch_r, start_x_r, start_y_r;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  // tracking state
  pos_t        lp_r [3];
  pos_t        vel_r [3];
  logic [31:0] last_stamp_r, last_pred_r;
  pos_t        tgt_x_r, tgt_y_r;

  // request payload
  pos_t        p_r [3];
  logic [31:0] stamp_r, arrival_r, dt_r;

  state_t      state_r;
  logic [1:0]  axis_r;
  status_t     status_r;
  logic        neg_r;
  pos_t        raw_r;
  logic signed [71:0] acc_r, mul_p_r, x_r;
  logic signed [35:0] mul_a, mul_b, s_r, t_r;

  logic        out_valid_r;
  pos_t        out_x_r, out_y_r;
  status_t     out_st_r;
  logic        out_load;

  dsu_req_t             du_req;
  dsu_rsp_t             du_rsp;
  logic [DSU_NUM_W-1:0] du_num, du_res;

  logic signed [32:0] diff;
  logic [32:0]        absd;
  logic [ALPHA_W-1:0] a_clamp, a_rest;
  logic signed [71:0] mix_sum, d2_sum, prod_sh;
  logic signed [71:0] raw_val;

  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[4:2];
  assign pready  = 1'b1;

  always_comb begin
    unique case (cfg_idx)
      REG_TRACK:   prdata = {31'd0, track_r};
      REG_PREDICT: prdata = {31'd0, predict_r};
      REG_ALPHA:   prdata = 32'(alpha_r);
      REG_CATCH:   prdata = catch_r;
      REG_START_X: prdata = start_x_r;
      REG_START_Y: prdata = start_y_r;
      default:     prdata = '0;
    endcase
  end

  assign diff    = 33'(p_r[axis_r]) - 33'(lp_r[axis_r]);
  assign absd    = diff[32] ? 33'(-diff) : 33'(diff);
  assign a_clamp = (alpha_r > 17'd65536) ? 17'd65536 : alpha_r;
  assign a_rest  = 17'd65536 - a_clamp;
  assign mix_sum = acc_r + mul_p_r;
  assign d2_sum  = acc_r + mul_p_r;
  assign prod_sh = mul_p_r >>> FRAC_BITS;
  assign raw_val = neg_r ? -72'(du_res) : 72'(du_res);
  assign out_load = (state_r == S_FIN) && (!out_valid_r || out_ch.ready);

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_VDIFF: begin
        mul_a = 36'(absd);
        mul_b = 36'sd1000000;
      end
      S_VMA: begin
        mul_a = 36'(a_clamp);
        mul_b = 36'(raw_r);
      end
      S_VMB: begin
        mul_a = 36'(a_rest);
        mul_b = 36'(vel_r[axis_r]);
      end
      S_DV2: begin
        mul_a = 36'(vel_r[2]);
        mul_b = 36'(vel_r[2]);
      end
      S_DG: begin
        mul_a = 36'(G2_FALL);
        mul_b = 36'(p_r[2]) - 36'(catch_r);
      end
      S_KS: begin
        mul_a = 36'(K_FALL);
        mul_b = s_r;
      end
      S_XM: begin
        mul_a = 36'(vel_r[0]);
        mul_b = t_r;
      end
      S_YM: begin
        mul_a = 36'(vel_r[1]);
        mul_b = t_r;
      end
      default: ;
    endcase
  end

  always_comb begin
    du_req.start = 1'b0;
    du_req.op    = DSU_DIV;
    du_num       = mul_p_r[DSU_NUM_W-1:0];
    if (state_r == S_VDIV) begin
      du_req.start = 1'b1;
    end else if (state_r == S_DSUM && !d2_sum[71]) begin
      du_req.start = 1'b1;
      du_req.op    = DSU_SQRT;
      du_num       = d2_sum[DSU_NUM_W-1:0];
    end
  end

  bip_dsu u_dsu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (du_req),
    .num   (du_num),
    .den   (dt_r),
    .rsp   (du_rsp),
    .res   (du_res)
  );

  always_ff @(posedge clk) begin
    mul_p_r <= mul_a * mul_b;
    if (!rst_n) begin
      track_r      <= 1'b0;
      predict_r    <= 1'b0;
      alpha_r      <= 17'd32768;
      catch_r      <= '0;
      start_x_r    <= '0;
      start_y_r    <= '0;
      tgt_x_r      <= '0;
      tgt_y_r      <= '0;
      last_stamp_r <= '0;
      last_pred_r  <= '0;
      for (int i = 0; i < 3; i++) begin
        lp_r[i]  <= '0;
        vel_r[i] <= '0;
      end
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      axis_r      <= '0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr) begin
        unique case (cfg_idx)
          REG_TRACK:   track_r   <= pwdata[0];
          REG_PREDICT: predict_r <= pwdata[0];
          REG_ALPHA:   alpha_r   <= pwdata[ALPHA_W-1:0];
          REG_CATCH:   catch_r   <= pwdata;
          REG_START_X: begin
            start_x_r <= pwdata;
            tgt_x_r   <= pwdata;
          end
          REG_START_Y: begin
            start_y_r <= pwdata;
            tgt_y_r   <= pwdata;
          end
          default: ;
        endcase
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            p_r[0]    <= in_ch.ball_x;
            p_r[1]    <= in_ch.ball_y;
            p_r[2]    <= in_ch.ball_z;
            stamp_r   <= in_ch.sample_stamp_us;
            arrival_r <= in_ch.arrival_time_us;
            state_r   <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          state_r <= S_FIN;
          if (!track_r) begin
            last_stamp_r <= stamp_r;
            status_r     <= ST_DISABLED;
          end else if (!predict_r) begin
            tgt_x_r  <= p_r[0];
            tgt_y_r  <= p_r[1];
            status_r <= ST_PASS;
          end else if ((arrival_r - last_pred_r) < TIMEOUT_W) begin
            dt_r         <= stamp_r - last_stamp_r;
            last_stamp_r <= stamp_r;
            last_pred_r  <= arrival_r;
            status_r     <= ST_REJECT;
            axis_r       <= '0;
            if (stamp_r != last_stamp_r) begin
              state_r <= S_VDIFF;
            end
          end else begin
            last_stamp_r <= stamp_r;
            last_pred_r  <= arrival_r;
            status_r     <= ST_RESYNC;
          end
        end
        S_VDIFF: begin
          neg_r   <= diff[32];
          state_r <= S_VDIV;
        end
        S_VDIV: state_r <= S_VDIVW;
        S_VDIVW: begin
          if (du_rsp.done) begin
            raw_r   <= sat32(raw_val);
            state_r <= S_VMA;
          end
        end
        S_VMA: state_r <= S_VMB;
        S_VMB: begin
          acc_r   <= mul_p_r;
          state_r <= S_VMIX;
        end
        S_VMIX: begin
          vel_r[axis_r] <= sat32(mix_sum >>> 16);
          if (axis_r == 2'd2) begin
            state_r <= S_DV2;
          end else begin
            axis_r  <= axis_r + 2'd1;
            state_r <= S_VDIFF;
          end
        end
        S_DV2: state_r <= S_DG;
        S_DG: begin
          acc_r   <= mul_p_r;
          state_r <= S_DSUM;
        end
        S_DSUM: begin
          // drop the prediction when there is no real root
          state_r <= d2_sum[71] ? S_FIN : S_SQW;
        end
        S_SQW: begin
          if (du_rsp.done) begin
            s_r     <= 36'(vel_r[2]) + 36'(du_res[31:0]);
            state_r <= S_KS;
          end
        end
        S_KS: state_r <= S_T;
        S_T: begin
          t_r     <= prod_sh[35:0];
          state_r <= S_XM;
        end
        S_XM: state_r <= S_YM;
        S_YM: begin
          x_r     <= 72'(p_r[0]) + prod_sh;
          state_r <= S_BOX;
        end
        S_BOX: begin
          if (x_r < X_HI && x_r > X_LO &&
              (72'(p_r[1]) + prod_sh) < Y_HI && (72'(p_r[1]) + prod_sh) > Y_LO) begin
            tgt_x_r  <= x_r[31:0];
            tgt_y_r  <= p_r[1] + prod_sh[31:0];
            status_r <= ST_PREDICT;
          end
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (out_load) begin
            for (int i = 0; i < 3; i++) begin
              lp_r[i] <= p_r[i];
            end
            out_x_r  <= tgt_x_r;
            out_y_r  <= tgt_y_r;
            out_st_r <= status_r;
            state_r  <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.target_x    = out_x_r;
  assign out_ch.target_y    = out_y_r;
  assign out_ch.step_status = out_st_r;

  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("request accepted while another is in flight");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.step_status <= ST_RESYNC)
    else $error("result status out of range");

  a_dsu_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    du_req.start |-> !du_rsp.busy)
    else $error("divide/sqrt unit started while busy");

  a_predict_only_predict_mode: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_VDIFF |-> track_r && predict_r && dt_r != 32'd0)
    else $error("velocity update outside predict mode");

endmodule
